>>> rtl/kms_pkg.sv
// shared types, codes and helpers of the keypad and led multiplex scanner
`timescale 1ns / 1ps

package kms_pkg;

  // default scan timing in ticks
  localparam int unsigned DeadtimeDefault = 5;
  localparam int unsigned HoldDefault     = 1;

  // field widths
  localparam int unsigned LineW  = 5;
  localparam int unsigned RowW   = 2;
  localparam int unsigned BtnW   = 8;
  localparam int unsigned BiasW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 3;

  // request commands
  localparam logic CmdScan = 1'b0;
  localparam logic CmdRead = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBiasSelect   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRangeSelect  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInductive    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCommonJoined = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPowerOn      = 3'd4;

  // bias preset codes
  localparam logic [BiasW-1:0] BiasPresetA = 3'd0;
  localparam logic [BiasW-1:0] BiasPresetB = 3'd1;
  localparam logic [BiasW-1:0] BiasPresetC = 3'd2;
  localparam logic [BiasW-1:0] BiasPresetD = 3'd3;

  typedef struct packed {
    logic             command;
    logic [LineW-1:0] line_sample;
  } req_t;

  typedef struct packed {
    logic [BiasW-1:0] bias_select;
    logic             range_select;
    logic             inductive_mode;
    logic             common_joined;
    logic             power_on;
  } cfg_t;

  typedef struct packed {
    logic             line_drive;
    logic [LineW-1:0] line_levels;
    logic [RowW-1:0]  button_rows_n;
    logic [RowW-1:0]  led_rows_n;
    logic [BtnW-1:0]  press_events;
  } res_t;

  // led row 0 bias pattern: line3 A, line2 B, line1 C, line0 D
  function automatic logic [LineW-1:0] bias_pattern(input logic [BiasW-1:0] sel);
    logic [LineW-1:0] pat;
    unique case (sel)
      BiasPresetA: pat = 5'h08;
      BiasPresetB: pat = 5'h04;
      BiasPresetC: pat = 5'h02;
      BiasPresetD: pat = 5'h01;
      default:     pat = 5'h09;
    endcase
    return pat;
  endfunction

endpackage

>>> rtl/kms_in_stage.sv
// input register of the scanner request channel
`timescale 1ns / 1ps

module kms_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kms_pkg::req_t req_i,
  input  logic          take_i,
  output logic          fire_o,
  output kms_pkg::req_t req_o
);

  logic          valid_q, valid_d;
  kms_pkg::req_t req_q;

  assign fire_o     = valid_q & take_i;
  assign in_ready_o = ~valid_q | take_i;
  assign req_o      = req_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_i;
    end
  end

endmodule

>>> rtl/kms_cfg.sv
// configuration registers of the scanner
`timescale 1ns / 1ps

module kms_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kms_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [kms_pkg::CfgDataW-1:0]   cfg_data_i,
  output kms_pkg::cfg_t                  cfg_o
);

  kms_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kms_pkg::RegBiasSelect:   cfg_d.bias_select    = cfg_data_i[kms_pkg::BiasW-1:0];
        kms_pkg::RegRangeSelect:  cfg_d.range_select   = cfg_data_i[0];
        kms_pkg::RegInductive:    cfg_d.inductive_mode = cfg_data_i[0];
        kms_pkg::RegCommonJoined: cfg_d.common_joined  = cfg_data_i[0];
        kms_pkg::RegPowerOn:      cfg_d.power_on       = cfg_data_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/kms_scan.sv
// scan phase sequencer, line and row registers and press detection
`timescale 1ns / 1ps

module kms_scan #(
  parameter int unsigned DEADTIME = kms_pkg::DeadtimeDefault,
  parameter int unsigned HOLD     = kms_pkg::HoldDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  kms_pkg::req_t req_i,
  input  kms_pkg::cfg_t cfg_i,
  output kms_pkg::res_t res_o
);

  localparam int unsigned CycleLen = 2 + DEADTIME + 2 * HOLD;
  localparam int unsigned PhLed0   = 2 + DEADTIME;
  localparam int unsigned PhLed1   = 2 + DEADTIME + HOLD;
  localparam int unsigned PhaseW   = $clog2(CycleLen);

  localparam logic [PhaseW-1:0] PhStart  = '0;
  localparam logic [PhaseW-1:0] PhRow1   = PhaseW'(1);
  localparam logic [PhaseW-1:0] PhLed0Q  = PhaseW'(PhLed0);
  localparam logic [PhaseW-1:0] PhLed1Q  = PhaseW'(PhLed1);
  localparam logic [PhaseW:0]   CycleEnd = (PhaseW + 1)'(CycleLen);

  logic [PhaseW-1:0]         phase_q, phase_d;
  logic [PhaseW:0]           phase_inc;
  logic [kms_pkg::BtnW-1:0]  btn_q, btn_d;
  logic [kms_pkg::BtnW-1:0]  prev_q, prev_d;
  logic [kms_pkg::BtnW-1:0]  pend_q, pend_d;
  logic                      drive_q, drive_d;
  logic [kms_pkg::LineW-1:0] level_q, level_d;
  logic [kms_pkg::RowW-1:0]  brow_q, brow_d;
  logic [kms_pkg::RowW-1:0]  lrow_q, lrow_d;
  logic [kms_pkg::BtnW-1:0]  events;

  assign phase_inc = {1'b0, phase_q} + 1'b1;

  always_comb begin
    phase_d = phase_q;
    btn_d   = btn_q;
    prev_d  = prev_q;
    pend_d  = pend_q;
    drive_d = drive_q;
    level_d = level_q;
    brow_d  = brow_q;
    lrow_d  = lrow_q;
    events  = '0;

    if (req_i.command == kms_pkg::CmdRead) begin
      events = pend_q;
      pend_d = '0;
    end else begin
      if (phase_q == PhStart) begin
        drive_d   = 1'b0;
        level_d   = '1;
        lrow_d[1] = 1'b1;
        brow_d[0] = 1'b0;
      end
      if (phase_q == PhRow1) begin
        btn_d[4:0] = req_i.line_sample;
        brow_d     = 2'b01;
      end
      if (phase_q == PhLed0Q) begin
        btn_d[7:5] = req_i.line_sample[2:0];
        brow_d[1]  = 1'b1;
        drive_d    = 1'b1;
        level_d    = kms_pkg::bias_pattern(cfg_i.bias_select)
                   | {~cfg_i.range_select, 4'h0};
        lrow_d[0]  = 1'b0;
      end
      if (phase_q == PhLed1Q) begin
        lrow_d  = 2'b01;
        level_d = {cfg_i.power_on, cfg_i.common_joined, cfg_i.inductive_mode,
                   ~cfg_i.inductive_mode, cfg_i.range_select};
      end
      // end of cycle: high to low transitions become pending presses
      if (phase_inc >= CycleEnd) begin
        phase_d = '0;
        pend_d  = pend_q | (prev_q & ~btn_d);
        prev_d  = btn_d;
      end else begin
        phase_d = phase_inc[PhaseW-1:0];
      end
    end

    res_o.line_drive    = drive_d;
    res_o.line_levels   = level_d;
    res_o.button_rows_n = brow_d;
    res_o.led_rows_n    = lrow_d;
    res_o.press_events  = events;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      btn_q   <= '0;
      prev_q  <= '0;
      pend_q  <= '0;
      drive_q <= 1'b0;
      level_q <= '0;
      brow_q  <= '0;
      lrow_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      btn_q   <= btn_d;
      prev_q  <= prev_d;
      pend_q  <= pend_d;
      drive_q <= drive_d;
      level_q <= level_d;
      brow_q  <= brow_d;
      lrow_q  <= lrow_d;
    end
  end

endmodule

>>> rtl/kms_out_stage.sv
// result register of the scanner result channel
`timescale 1ns / 1ps

module kms_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  kms_pkg::res_t res_i,
  output logic          take_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kms_pkg::res_t res_o
);

  logic          valid_q, valid_d;
  kms_pkg::res_t res_q;

  assign take_o      = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = fire_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> rtl/keypad_led_multiplex_scanner.sv
// top level of the multiplexed keypad and led front-panel scanner
// a request is held in the input register, then its result in the result register
// throughput: one request per cycle, set by the single compute stage between the
//   input register and the result register; stalls only when the result is not taken
// reset: asynchronous, clears phase, button history, pending presses, line and row
//   registers and all configuration registers to zero; no clearing pass
`timescale 1ns / 1ps

module keypad_led_multiplex_scanner #(
  parameter int unsigned DEADTIME = kms_pkg::DeadtimeDefault,
  parameter int unsigned HOLD     = kms_pkg::HoldDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kms_pkg::CfgDataW-1:0]  cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [kms_pkg::LineW-1:0]     line_sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          line_drive_o,
  output logic [kms_pkg::LineW-1:0]     line_levels_o,
  output logic [kms_pkg::RowW-1:0]      button_rows_n_o,
  output logic [kms_pkg::RowW-1:0]      led_rows_n_o,
  output logic [kms_pkg::BtnW-1:0]      press_events_o
);

  kms_pkg::req_t req_in, req_reg;
  kms_pkg::cfg_t cfg;
  kms_pkg::res_t res_next, res_reg;
  logic          fire;   // request in the input register is processed this cycle
  logic          take;   // result register can load

  assign req_in.command     = command_i;
  assign req_in.line_sample = line_sample_i;

  // request register, frees itself whenever the result register can load
  kms_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req_in),
    .take_i     (take),
    .fire_o     (fire),
    .req_o      (req_reg)
  );

  // panel settings; users write them only while idle, the block does not enforce it
  kms_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // scan sequencer: a tick advances the phase, a read returns and clears presses
  kms_scan #(
    .DEADTIME (DEADTIME),
    .HOLD     (HOLD)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_reg),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  // result register, keeps its value while the consumer stalls
  kms_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res_next),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_reg)
  );

  assign line_drive_o    = res_reg.line_drive;
  assign line_levels_o   = res_reg.line_levels;
  assign button_rows_n_o = res_reg.button_rows_n;
  assign led_rows_n_o    = res_reg.led_rows_n;
  assign press_events_o  = res_reg.press_events;

endmodule

>>> rtl/kms_checker.sv
// port-level checks of the scanner and their binding to the top level
`timescale 1ns / 1ps

module kms_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          line_drive_o,
  input logic [kms_pkg::LineW-1:0]     line_levels_o,
  input logic [kms_pkg::RowW-1:0]      button_rows_n_o,
  input logic [kms_pkg::RowW-1:0]      led_rows_n_o,
  input logic [kms_pkg::BtnW-1:0]      press_events_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its press mask
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(press_events_o))
    else $error("press mask changed while stalled");

  // with lines released they are either idle low or pulled up
  a_released_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_drive_o |-> (line_levels_o == 5'h00 || line_levels_o == 5'h1f))
    else $error("released lines carry a led pattern");

  // driven lines never meet a selected button row, and some led row is lit
  a_drive_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_drive_o |-> button_rows_n_o == 2'b11 && led_rows_n_o != 2'b11)
    else $error("driven lines with a button row selected or no led row lit");

endmodule

bind keypad_led_multiplex_scanner kms_checker u_kms_checker (.*);
